### src/pra_pkg.sv
`timescale 1ns / 1ps

package pra_pkg;

    // Default sizing of the managed chunk
    localparam int MAX_PAGES_DEF = 1024;
    localparam int WORD_BITS_DEF = 64;
    localparam int LIMIT_RESET   = 1024;

    // Field widths on the stream ports
    localparam int CNT_W      = 11;
    localparam int START_W    = 10;
    localparam int BASE_W     = 10;
    localparam int ST_W       = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_RUN   = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_FREE = 2'd2;

    // Request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Word operations applied by the head unit
    localparam logic [1:0] OP_KEEP  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_SET   = 2'd2;

    // Control of every map cell
    typedef struct packed {
        logic shift;
        logic dir_down;
        logic fill;
    } t_cell_ctl;

    // Control of the head unit
    typedef struct packed {
        logic       dir_down;
        logic [1:0] op;
    } t_head_ctl;

    // Status from the head unit
    typedef struct packed {
        logic found;
        logic any_free;
    } t_head_stat;

endpackage

### src/pra_cell.sv
`timescale 1ns / 1ps

module pra_cell #(
    parameter int W = pra_pkg::WORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pra_pkg::t_cell_ctl  i_ctl,
    input  logic [W-1:0]        i_prev,
    input  logic [W-1:0]        i_next,
    output logic [W-1:0]        o_word
);

    logic [W-1:0] r_word;

    // Hold one map word; fill to all free, or take a neighbor's word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '1;
        end else if (i_ctl.fill) begin
            r_word <= '1;
        end else if (i_ctl.shift) begin
            r_word <= i_ctl.dir_down ? i_prev : i_next;
        end
    end

    assign o_word = r_word;

endmodule

### src/pra_head.sv
`timescale 1ns / 1ps

module pra_head #(
    parameter int W  = pra_pkg::WORD_BITS_DEF,
    parameter int AW = 12
) (
    input  pra_pkg::t_head_ctl        i_ctl,
    input  logic [W-1:0]              i_word,
    input  logic [AW-1:0]             i_word_page,
    input  logic [pra_pkg::CNT_W-1:0] i_limit,
    input  logic [pra_pkg::CNT_W-1:0] i_need,
    input  logic [pra_pkg::CNT_W-1:0] i_run_in,
    input  logic [AW-1:0]             i_lo,
    input  logic [AW-1:0]             i_hi,
    output logic [W-1:0]              o_word,
    output pra_pkg::t_head_stat       o_stat,
    output logic [pra_pkg::CNT_W-1:0] o_run_out,
    output logic [AW-1:0]             o_base
);

    localparam int JW = $clog2(W);
    localparam int LG = $clog2(W);
    localparam int LW = pra_pkg::CNT_W + 1;

    logic [W-1:0]  free_bits;
    logic [AW-1:0] scan_page [W];
    logic [AW-1:0] nat_page  [W];
    logic          hz [LG+1][W];
    logic [JW-1:0] pz [LG+1][W];
    logic [LW-1:0] run_len [W];
    logic [W-1:0]  hit;
    logic [W-1:0]  range_m;
    logic [JW-1:0] hit_idx;

    always_comb begin
        // Present the word in scan order, pages at or above the limit count as used
        for (int j = 0; j < W; j++) begin
            scan_page[j] = i_ctl.dir_down ? i_word_page + AW'(W - 1 - j)
                                          : i_word_page + AW'(j);
            free_bits[j] = (i_ctl.dir_down ? i_word[W - 1 - j] : i_word[j])
                           && (scan_page[j] < AW'(i_limit));
        end

        // Prefix search for the last used page at or before each position
        for (int j = 0; j < W; j++) begin
            hz[0][j] = ~free_bits[j];
            pz[0][j] = JW'(j);
        end
        for (int l = 0; l < LG; l++) begin
            for (int j = 0; j < W; j++) begin
                if (j >= (1 << l) && !hz[l][j]) begin
                    hz[l+1][j] = hz[l][j - (1 << l)];
                    pz[l+1][j] = pz[l][j - (1 << l)];
                end else begin
                    hz[l+1][j] = hz[l][j];
                    pz[l+1][j] = pz[l][j];
                end
            end
        end

        // Free run length ending at each position, carried run included
        for (int j = 0; j < W; j++) begin
            run_len[j] = hz[LG][j] ? (LW'(j) - LW'(pz[LG][j]))
                                   : (LW'(i_run_in) + LW'(j + 1));
            hit[j]     = free_bits[j] && (run_len[j] >= LW'(i_need));
        end

        // Pick the first position that completes a run
        hit_idx = '0;
        for (int j = W - 1; j >= 0; j--) begin
            if (hit[j]) begin
                hit_idx = JW'(j);
            end
        end

        o_base = i_ctl.dir_down ? (i_word_page + AW'(W - 1) - AW'(hit_idx))
                                : (i_word_page + AW'(hit_idx) + AW'(1) - AW'(i_need));
        o_run_out = run_len[W-1][pra_pkg::CNT_W-1:0];

        // Mark the pages of the current range in natural order
        for (int j = 0; j < W; j++) begin
            nat_page[j] = i_word_page + AW'(j);
            range_m[j]  = (nat_page[j] >= i_lo) && (nat_page[j] < i_hi);
        end

        case (i_ctl.op)
            pra_pkg::OP_CLEAR: o_word = i_word & ~range_m;
            pra_pkg::OP_SET:   o_word = i_word | range_m;
            default:           o_word = i_word;
        endcase

        o_stat.found    = |hit;
        o_stat.any_free = |(i_word & range_m);
    end

endmodule

### src/page_run_allocator.sv
`timescale 1ns / 1ps
// Channel   | Dir | Handshake               | Payload
// s (req)   | in  | i_s_tvalid / o_s_tready | tdata: page_count, start_page, search_from_top
//           |     |                         | tuser: action
// m (res)   | out | o_m_tvalid / i_m_tready | tdata: base_page, free_count, all_free
//           |     |                         | tuser: status
// cfg       | in  | i_cfg_we                | i_cfg_wdata: page_limit
//
// NW = MAX_PAGES/MAP_WORD_BITS (rounded up) word cells form a ring that rotates one word per
// cycle past the head while a pass runs. Allocate runs a search pass, then a mark pass; free
// runs a check pass, then a set pass. The result goes to the output register after the second
// pass, and a new request is accepted after that hand-off. A failed search or check takes one
// pass; refused requests skip the passes. Reset and page_limit writes refill the map to all free.
// A finished result waits in the output register; the next request stalls only at its own result.

module page_run_allocator #(
    parameter int MAX_PAGES     = pra_pkg::MAX_PAGES_DEF,
    parameter int MAP_WORD_BITS = pra_pkg::WORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [10:0] page_count, [20:11] start_page, [21] search_from_top
    input  logic [pra_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [0] action
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [9:0] base_page, [20:10] free_count, [21] all_free
    output logic [pra_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // [1:0] status
    output logic [pra_pkg::ST_W-1:0]       o_m_tuser,
    input  logic                           i_cfg_we,
    input  logic [pra_pkg::CNT_W-1:0]      i_cfg_wdata
);

    localparam int CW         = pra_pkg::CNT_W;
    localparam int NW         = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WI_W       = (NW > 1) ? $clog2(NW) : 1;
    localparam int PG_W       = $clog2(MAX_PAGES);
    localparam int AW         = ((PG_W > CW) ? PG_W : CW) + 1;
    localparam int LIMIT_INIT = (pra_pkg::LIMIT_RESET > MAX_PAGES) ? MAX_PAGES
                                                                   : pra_pkg::LIMIT_RESET;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_MARK = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_SETP = 3'd4;
    localparam logic [2:0] S_RESP = 3'd5;

    // Request fields
    logic                         in_action;
    logic [CW-1:0]                in_count;
    logic [pra_pkg::START_W-1:0]  in_start;
    logic                         in_top;

    logic [2:0]                   r_state, n_state;
    logic [WI_W-1:0]              r_cnt, n_cnt;
    logic                         r_dir, n_dir;
    logic                         r_act, n_act;
    logic [CW-1:0]                r_need, n_need;
    logic [CW-1:0]                r_run, n_run;
    logic                         r_found, n_found;
    logic                         r_bad, n_bad;
    logic [AW-1:0]                r_lo, n_lo;
    logic [AW-1:0]                r_hi, n_hi;
    logic [pra_pkg::ST_W-1:0]     r_status, n_status;
    logic [CW-1:0]                r_free, n_free;
    logic [CW-1:0]                r_limit, n_limit;
    logic                         r_out_valid, n_out_valid;
    logic [pra_pkg::ST_W-1:0]     r_out_status, n_out_status;
    logic [pra_pkg::BASE_W-1:0]   r_out_base, n_out_base;
    logic [CW-1:0]                r_out_free, n_out_free;
    logic                         r_out_all, n_out_all;

    logic                         last;
    logic [CW-1:0]                cfg_limit;
    logic [WI_W-1:0]              word_idx;
    logic [AW-1:0]                word_page;
    pra_pkg::t_cell_ctl           cell_ctl;
    pra_pkg::t_head_ctl           head_ctl;
    pra_pkg::t_head_stat          head_stat;
    logic [MAP_WORD_BITS-1:0]     cell_word [NW];
    logic [MAP_WORD_BITS-1:0]     head_in;
    logic [MAP_WORD_BITS-1:0]     head_out;
    logic [CW-1:0]                head_run;
    logic [AW-1:0]                head_base;

    assign in_count  = i_s_tdata[10:0];
    assign in_start  = i_s_tdata[20:11];
    assign in_top    = i_s_tdata[21];
    assign in_action = i_s_tuser;

    // Map ring: each cell passes its word on while a pass runs
    assign cell_ctl.shift    = (r_state == S_SRCH) || (r_state == S_MARK) ||
                               (r_state == S_CHK)  || (r_state == S_SETP);
    assign cell_ctl.dir_down = r_dir;
    assign cell_ctl.fill     = i_cfg_we;

    for (genvar i = 0; i < NW; i++) begin : g_cell
        logic [MAP_WORD_BITS-1:0] prev_w;
        logic [MAP_WORD_BITS-1:0] next_w;
        if (i == 0) begin : g_lo
            assign prev_w = head_out;
        end else begin : g_lo_mid
            assign prev_w = cell_word[i-1];
        end
        if (i == NW - 1) begin : g_hi
            assign next_w = head_out;
        end else begin : g_hi_mid
            assign next_w = cell_word[i+1];
        end
        pra_cell #(
            .W (MAP_WORD_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl),
            .i_prev  (prev_w),
            .i_next  (next_w),
            .o_word  (cell_word[i])
        );
    end

    // Head unit sees the word leaving the ring
    assign head_in   = r_dir ? cell_word[NW-1] : cell_word[0];
    assign word_idx  = r_dir ? (WI_W'(NW - 1) - r_cnt) : r_cnt;
    assign word_page = AW'(word_idx) * AW'(MAP_WORD_BITS);

    assign head_ctl.dir_down = r_dir;
    assign head_ctl.op       = (r_state == S_MARK) ? pra_pkg::OP_CLEAR :
                               (r_state == S_SETP) ? pra_pkg::OP_SET : pra_pkg::OP_KEEP;

    pra_head #(
        .W  (MAP_WORD_BITS),
        .AW (AW)
    ) u_head (
        .i_ctl       (head_ctl),
        .i_word      (head_in),
        .i_word_page (word_page),
        .i_limit     (r_limit),
        .i_need      (r_need),
        .i_run_in    (r_run),
        .i_lo        (r_lo),
        .i_hi        (r_hi),
        .o_word      (head_out),
        .o_stat      (head_stat),
        .o_run_out   (head_run),
        .o_base      (head_base)
    );

    assign last = (r_cnt == WI_W'(NW - 1));

    // Clamp a written page limit into 1 .. MAX_PAGES
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_limit = CW'(1);
        end else if (32'(i_cfg_wdata) > MAX_PAGES) begin
            cfg_limit = CW'(MAX_PAGES);
        end else begin
            cfg_limit = i_cfg_wdata;
        end
    end

    // Sequencer: immediate checks, passes over the ring, result hand-off
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_dir        = r_dir;
        n_act        = r_act;
        n_need       = r_need;
        n_run        = r_run;
        n_found      = r_found;
        n_bad        = r_bad;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_status     = r_status;
        n_free       = r_free;
        n_limit      = r_limit;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_base   = r_out_base;
        n_out_free   = r_out_free;
        n_out_all    = r_out_all;

        // Drop a taken result
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_act   = in_action;
                    n_need  = in_count;
                    n_lo    = AW'(in_start);
                    n_hi    = AW'(in_start) + AW'(in_count);
                    n_dir   = 1'b0;
                    n_cnt   = '0;
                    n_run   = '0;
                    n_found = 1'b0;
                    n_bad   = 1'b0;
                    if (in_action == pra_pkg::ACT_ALLOC) begin
                        if (in_count == '0 || in_count > r_free) begin
                            n_status = pra_pkg::ST_NO_RUN;
                            n_state  = S_RESP;
                        end else begin
                            n_dir   = in_top;
                            n_state = S_SRCH;
                        end
                    end else begin
                        if (in_count == '0 ||
                            ((CW+1)'(in_start) + (CW+1)'(in_count)) > (CW+1)'(r_limit)) begin
                            n_status = pra_pkg::ST_BAD_FREE;
                            n_state  = S_RESP;
                        end else begin
                            n_state = S_CHK;
                        end
                    end
                end
            end
            S_SRCH: begin
                n_cnt = r_cnt + WI_W'(1);
                if (!r_found) begin
                    n_run = head_run;
                    if (head_stat.found) begin
                        n_found = 1'b1;
                        n_lo    = head_base;
                        n_hi    = head_base + AW'(r_need);
                    end
                end
                if (last) begin
                    n_cnt = '0;
                    if (r_found || head_stat.found) begin
                        n_dir   = 1'b0;
                        n_state = S_MARK;
                    end else begin
                        n_status = pra_pkg::ST_NO_RUN;
                        n_state  = S_RESP;
                    end
                end
            end
            S_MARK: begin
                n_cnt = r_cnt + WI_W'(1);
                if (last) begin
                    n_cnt    = '0;
                    n_free   = r_free - r_need;
                    n_status = pra_pkg::ST_OK;
                    n_state  = S_RESP;
                end
            end
            S_CHK: begin
                n_cnt = r_cnt + WI_W'(1);
                n_bad = r_bad | head_stat.any_free;
                if (last) begin
                    n_cnt = '0;
                    if (r_bad || head_stat.any_free) begin
                        n_status = pra_pkg::ST_BAD_FREE;
                        n_state  = S_RESP;
                    end else begin
                        n_state = S_SETP;
                    end
                end
            end
            S_SETP: begin
                n_cnt = r_cnt + WI_W'(1);
                if (last) begin
                    n_cnt    = '0;
                    n_free   = r_free + r_need;
                    n_status = pra_pkg::ST_OK;
                    n_state  = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_base   = (r_status == pra_pkg::ST_OK && r_act == pra_pkg::ACT_ALLOC)
                                   ? r_lo[pra_pkg::BASE_W-1:0] : '0;
                    n_out_free   = r_free;
                    n_out_all    = (r_free == r_limit);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Page limit write restarts the chunk all free
        if (i_cfg_we) begin
            n_limit = cfg_limit;
            n_free  = cfg_limit;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_dir       <= 1'b0;
            r_found     <= 1'b0;
            r_bad       <= 1'b0;
            r_free      <= CW'(LIMIT_INIT);
            r_limit     <= CW'(LIMIT_INIT);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_dir       <= n_dir;
            r_found     <= n_found;
            r_bad       <= n_bad;
            r_free      <= n_free;
            r_limit     <= n_limit;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_act        <= n_act;
        r_need       <= n_need;
        r_run        <= n_run;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_base   <= n_out_base;
        r_out_free   <= n_out_free;
        r_out_all    <= n_out_all;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {2'b00, r_out_all, r_out_free, r_out_base};

    // Free count never passes the chunk size
    a_free_le_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_limit)
        else $error("free count above page limit");

    // Marking runs only after a run was found
    a_mark_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> r_found)
        else $error("mark pass without a found run");

    // Ring is back in place whenever the sequencer rests
    a_idle_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cnt == '0))
        else $error("pass counter not at rest in idle");

    // Setting pages only follows a clean check pass
    a_set_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETP) |-> !r_bad)
        else $error("set pass after a failed check");

    // Refused requests report base zero
    a_base_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != pra_pkg::ST_OK) |-> (o_m_tdata[pra_pkg::BASE_W-1:0] == '0))
        else $error("nonzero base on refused request");

endmodule
